### design/jvsc_pkg.sv
// Types, constants and a helper function shared by the JSON value checker.
`timescale 1ns / 1ps
package jvsc_pkg;

	localparam int QDEPTH = 4;
	localparam int QAW = 2;

	typedef enum logic [3:0] {
		MD_VALUE,
		MD_ARR1,
		MD_OBJ1,
		MD_KEY,
		MD_COLON,
		MD_AFTER,
		MD_LIT,
		MD_NSIGN,
		MD_NINT,
		MD_NFRAC0,
		MD_NFRAC,
		MD_NEXP0,
		MD_NEXPS,
		MD_NEXP,
		MD_DONE,
		MD_STR
	} mode_t;

	typedef enum logic [2:0] {
		SB_CHAR,
		SB_ESC,
		SB_HEX1,
		SB_WAITBS,
		SB_WAITU,
		SB_HEX2
	} sub_t;

	typedef enum logic [2:0] {
		UR_ANY,
		UR_A0,
		UR_9F,
		UR_90,
		UR_8F
	} rule_t;

	typedef struct packed {
		logic       ws;
		logic       digit;
		logic       hex_ok;
		logic [3:0] hex_val;
	} byte_class_t;

	typedef struct packed {
		logic [7:0]  text;
		logic        last;
		byte_class_t cls;
	} item_t;

	function automatic logic [7:0] lit_char(input logic [3:0] pos);
		logic [7:0] c;
		case (pos)
			4'd0:    c = "t";
			4'd1:    c = "r";
			4'd2:    c = "u";
			4'd3:    c = "e";
			4'd4:    c = "f";
			4'd5:    c = "a";
			4'd6:    c = "l";
			4'd7:    c = "s";
			4'd8:    c = "e";
			4'd9:    c = "n";
			4'd10:   c = "u";
			4'd11:   c = "l";
			4'd12:   c = "l";
			default: c = 8'h00;
		endcase
		return c;
	endfunction

endpackage

### design/jvsc_front.sv
// Front end: accept bytes, classify them and queue them for the parser.
`timescale 1ns / 1ps
module jvsc_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  logic [7:0]      in_text,
	input  logic            in_last,
	output logic            q_valid,
	input  logic            q_pop,
	output jvsc_pkg::item_t q_item
);

	jvsc_pkg::item_t               mem_q [jvsc_pkg::QDEPTH];
	logic [jvsc_pkg::QAW-1:0]      wptr_q;
	logic [jvsc_pkg::QAW-1:0]      rptr_q;
	logic [jvsc_pkg::QAW:0]        cnt_q;
	jvsc_pkg::byte_class_t         cls;
	logic                          push;
	logic                          pop;
	logic                          is_lc;
	logic                          is_uc;

	always_comb begin
		cls.ws    = (in_text == " ") || (in_text == 8'h09) || (in_text == 8'h0d) ||
			(in_text == 8'h0a);
		cls.digit = (in_text >= "0") && (in_text <= "9");
		is_lc     = (in_text >= "a") && (in_text <= "f");
		is_uc     = (in_text >= "A") && (in_text <= "F");
		cls.hex_ok = cls.digit || is_lc || is_uc;
		cls.hex_val = cls.digit ? in_text[3:0] : 4'(in_text[3:0] + 4'd9);
	end

	assign in_ready = (cnt_q != (jvsc_pkg::QAW+1)'(jvsc_pkg::QDEPTH));
	assign q_valid  = (cnt_q != '0);
	assign push     = in_valid && in_ready;
	assign pop      = q_pop && q_valid;
	assign q_item   = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q] <= '{text: in_text, last: in_last, cls: cls};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (push) wptr_q <= wptr_q + 1'b1;
			if (pop) rptr_q <= rptr_q + 1'b1;
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

### design/jvsc_back.sv
// Back end: parse state machine, container stack and verdict register.
`timescale 1ns / 1ps
module jvsc_back #(
	parameter int MAX_NEST = 64
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            q_valid,
	output logic            q_pop,
	input  jvsc_pkg::item_t q_item,
	output logic            out_valid,
	input  logic            out_ready,
	output logic            out_verdict
);

	localparam int SW = $clog2(MAX_NEST + 1) < 1 ? 1 : $clog2(MAX_NEST + 1);
	localparam int NW = $clog2(MAX_NEST + 2);

	jvsc_pkg::mode_t  mode_q, mode_d, em;
	jvsc_pkg::sub_t   sub_q, sub_d;
	jvsc_pkg::rule_t  rule_q, rule_d;
	logic             key_q, key_d;
	logic [NW-1:0]    nest_q, nest_d;
	logic [3:0]       lit_q, lit_d;
	logic [15:0]      hex_q, hex_d, acc_n;
	logic [2:0]       hcnt_q, hcnt_d, cnt_n;
	logic [1:0]       pend_q, pend_d;
	logic             top_q, top_d;
	logic             below_q;
	logic             stk_q [MAX_NEST + 1];
	logic [SW-1:0]    rd_addr;
	logic             push, pop, fin, ver, term, sv;
	logic             out_v_q, out_d_q;
	logic [7:0]       b;
	logic [7:0]       lo, hi;
	jvsc_pkg::byte_class_t c;

	assign q_pop       = q_valid && (!out_v_q || out_ready);
	assign out_valid   = out_v_q;
	assign out_verdict = out_d_q;
	assign b           = q_item.text;
	assign c           = q_item.cls;
	assign acc_n       = {hex_q[11:0], c.hex_val};
	assign cnt_n       = hcnt_q + 3'd1;

	always_comb begin
		term = 1'b0;
		case (mode_q)
			jvsc_pkg::MD_NINT:  term = !(c.digit || b == "." || b == "e" || b == "E");
			jvsc_pkg::MD_NFRAC: term = !(c.digit || b == "e" || b == "E");
			jvsc_pkg::MD_NEXP:  term = !c.digit;
			default:            term = 1'b0;
		endcase
	end

	always_comb begin
		lo = 8'h80;
		hi = 8'hbf;
		case (rule_q)
			jvsc_pkg::UR_A0: lo = 8'ha0;
			jvsc_pkg::UR_9F: hi = 8'h9f;
			jvsc_pkg::UR_90: lo = 8'h90;
			jvsc_pkg::UR_8F: hi = 8'h8f;
			default: ;
		endcase
	end

	always_comb begin
		mode_d = mode_q; sub_d = sub_q; key_d = key_q; nest_d = nest_q;
		lit_d = lit_q; hex_d = hex_q; hcnt_d = hcnt_q; pend_d = pend_q;
		rule_d = rule_q; top_d = top_q;
		push = 1'b0; pop = 1'b0; fin = 1'b0; ver = 1'b0; sv = 1'b0;
		em = mode_q;
		if (term) begin
			if (nest_q == '0) begin
				fin = 1'b1;
				em  = jvsc_pkg::MD_DONE;
			end else begin
				em     = jvsc_pkg::MD_AFTER;
				mode_d = jvsc_pkg::MD_AFTER;
			end
		end
		if (!fin) begin
			case (em)
				jvsc_pkg::MD_VALUE: begin
					if (!c.ws) sv = 1'b1;
				end
				jvsc_pkg::MD_ARR1: begin
					if (!c.ws) begin
						if (b == "]") begin
							pop = 1'b1;
						end else if (nest_q > NW'(MAX_NEST)) begin
							fin = 1'b1; ver = 1'b1;
						end else begin
							sv = 1'b1;
						end
					end
				end
				jvsc_pkg::MD_OBJ1: begin
					if (!c.ws) begin
						if (b == "}") pop = 1'b1;
						else if (b == "\"") begin
							mode_d = jvsc_pkg::MD_STR; key_d = 1'b1;
							sub_d = jvsc_pkg::SB_CHAR; pend_d = '0; rule_d = jvsc_pkg::UR_ANY;
						end else begin
							fin = 1'b1; ver = 1'b1;
						end
					end
				end
				jvsc_pkg::MD_KEY: begin
					if (!c.ws) begin
						if (b == "\"") begin
							mode_d = jvsc_pkg::MD_STR; key_d = 1'b1;
							sub_d = jvsc_pkg::SB_CHAR; pend_d = '0; rule_d = jvsc_pkg::UR_ANY;
						end else begin
							fin = 1'b1; ver = 1'b1;
						end
					end
				end
				jvsc_pkg::MD_COLON: begin
					if (!c.ws) begin
						if (b == ":" && !(nest_q > NW'(MAX_NEST))) mode_d = jvsc_pkg::MD_VALUE;
						else begin
							fin = 1'b1; ver = 1'b1;
						end
					end
				end
				jvsc_pkg::MD_AFTER: begin
					if (!c.ws) begin
						if (b == ",") begin
							if (top_q) mode_d = jvsc_pkg::MD_KEY;
							else if (nest_q > NW'(MAX_NEST)) begin
								fin = 1'b1; ver = 1'b1;
							end else mode_d = jvsc_pkg::MD_VALUE;
						end else if (b == (top_q ? 8'h7d : 8'h5d)) begin
							pop = 1'b1;
						end else begin
							fin = 1'b1; ver = 1'b1;
						end
					end
				end
				jvsc_pkg::MD_LIT: begin
					if (lit_q < 4'd13 && b == jvsc_pkg::lit_char(lit_q)) begin
						lit_d = lit_q + 4'd1;
						if (lit_d == 4'd4 || lit_d == 4'd9 || lit_d == 4'd13) begin
							if (nest_q == '0) fin = 1'b1;
							else mode_d = jvsc_pkg::MD_AFTER;
						end
					end else begin
						fin = 1'b1; ver = 1'b1;
					end
				end
				jvsc_pkg::MD_NSIGN: begin
					if (c.digit) mode_d = jvsc_pkg::MD_NINT;
					else begin
						fin = 1'b1; ver = 1'b1;
					end
				end
				jvsc_pkg::MD_NINT: begin
					if (b == ".") mode_d = jvsc_pkg::MD_NFRAC0;
					else if (b == "e" || b == "E") mode_d = jvsc_pkg::MD_NEXP0;
				end
				jvsc_pkg::MD_NFRAC0: begin
					if (c.digit) mode_d = jvsc_pkg::MD_NFRAC;
					else begin
						fin = 1'b1; ver = 1'b1;
					end
				end
				jvsc_pkg::MD_NFRAC: begin
					if (b == "e" || b == "E") mode_d = jvsc_pkg::MD_NEXP0;
				end
				jvsc_pkg::MD_NEXP0: begin
					if (b == "+" || b == "-") mode_d = jvsc_pkg::MD_NEXPS;
					else if (c.digit) mode_d = jvsc_pkg::MD_NEXP;
					else begin
						fin = 1'b1; ver = 1'b1;
					end
				end
				jvsc_pkg::MD_NEXPS: begin
					if (c.digit) mode_d = jvsc_pkg::MD_NEXP;
					else begin
						fin = 1'b1; ver = 1'b1;
					end
				end
				jvsc_pkg::MD_NEXP: ;
				jvsc_pkg::MD_STR: begin
					case (sub_q)
						jvsc_pkg::SB_CHAR: begin
							if (b < 8'h20) begin
								fin = 1'b1; ver = 1'b1;
							end else if (b == "\"") begin
								if (pend_q != '0) begin
									fin = 1'b1; ver = 1'b1;
								end else if (key_q) mode_d = jvsc_pkg::MD_COLON;
								else if (nest_q == '0) fin = 1'b1;
								else mode_d = jvsc_pkg::MD_AFTER;
							end else if (b == "\\") begin
								if (pend_q != '0) begin
									fin = 1'b1; ver = 1'b1;
								end else sub_d = jvsc_pkg::SB_ESC;
							end else if (pend_q != '0) begin
								if (b < lo || b > hi) begin
									fin = 1'b1; ver = 1'b1;
								end else begin
									pend_d = pend_q - 2'd1;
									rule_d = jvsc_pkg::UR_ANY;
								end
							end else if (b >= 8'h80) begin
								if (b >= 8'hc2 && b <= 8'hdf) begin
									pend_d = 2'd1; rule_d = jvsc_pkg::UR_ANY;
								end else if (b == 8'he0) begin
									pend_d = 2'd2; rule_d = jvsc_pkg::UR_A0;
								end else if (b == 8'hed) begin
									pend_d = 2'd2; rule_d = jvsc_pkg::UR_9F;
								end else if (b >= 8'he1 && b <= 8'hef) begin
									pend_d = 2'd2; rule_d = jvsc_pkg::UR_ANY;
								end else if (b == 8'hf0) begin
									pend_d = 2'd3; rule_d = jvsc_pkg::UR_90;
								end else if (b >= 8'hf1 && b <= 8'hf3) begin
									pend_d = 2'd3; rule_d = jvsc_pkg::UR_ANY;
								end else if (b == 8'hf4) begin
									pend_d = 2'd3; rule_d = jvsc_pkg::UR_8F;
								end else begin
									fin = 1'b1; ver = 1'b1;
								end
							end
						end
						jvsc_pkg::SB_ESC: begin
							if (b == "\"" || b == "\\" || b == "/" || b == "b" || b == "f" ||
								b == "n" || b == "r" || b == "t") begin
								sub_d = jvsc_pkg::SB_CHAR;
							end else if (b == "u") begin
								hex_d = '0; hcnt_d = '0; sub_d = jvsc_pkg::SB_HEX1;
							end else begin
								fin = 1'b1; ver = 1'b1;
							end
						end
						jvsc_pkg::SB_HEX1, jvsc_pkg::SB_HEX2: begin
							if (!c.hex_ok) begin
								fin = 1'b1; ver = 1'b1;
							end else begin
								hex_d  = acc_n;
								hcnt_d = cnt_n;
								if (cnt_n == 3'd4) begin
									if (sub_q == jvsc_pkg::SB_HEX1) begin
										if (acc_n >= 16'hd800 && acc_n <= 16'hdbff) begin
											sub_d = jvsc_pkg::SB_WAITBS;
										end else if (acc_n == 16'h0000 ||
											(acc_n >= 16'hdc00 && acc_n <= 16'hdfff)) begin
											fin = 1'b1; ver = 1'b1;
										end else sub_d = jvsc_pkg::SB_CHAR;
									end else if (acc_n >= 16'hdc00 && acc_n <= 16'hdfff) begin
										sub_d = jvsc_pkg::SB_CHAR;
									end else begin
										fin = 1'b1; ver = 1'b1;
									end
								end
							end
						end
						jvsc_pkg::SB_WAITBS: begin
							if (b == "\\") sub_d = jvsc_pkg::SB_WAITU;
							else begin
								fin = 1'b1; ver = 1'b1;
							end
						end
						jvsc_pkg::SB_WAITU: begin
							if (b == "u") begin
								hex_d = '0; hcnt_d = '0; sub_d = jvsc_pkg::SB_HEX2;
							end else begin
								fin = 1'b1; ver = 1'b1;
							end
						end
						default: begin
							fin = 1'b1; ver = 1'b1;
						end
					endcase
				end
				default: ;
			endcase
		end
		if (sv) begin
			if (b == "\"") begin
				mode_d = jvsc_pkg::MD_STR; key_d = 1'b0;
				sub_d = jvsc_pkg::SB_CHAR; pend_d = '0; rule_d = jvsc_pkg::UR_ANY;
			end else if (b == "{" || b == "[") begin
				if (nest_q > NW'(MAX_NEST)) begin
					fin = 1'b1; ver = 1'b1;
				end else begin
					push   = 1'b1;
					top_d  = (b == "{");
					nest_d = nest_q + 1'b1;
					mode_d = (b == "{") ? jvsc_pkg::MD_OBJ1 : jvsc_pkg::MD_ARR1;
				end
			end else if (b == "t") begin
				lit_d = 4'd1; mode_d = jvsc_pkg::MD_LIT;
			end else if (b == "f") begin
				lit_d = 4'd5; mode_d = jvsc_pkg::MD_LIT;
			end else if (b == "n") begin
				lit_d = 4'd10; mode_d = jvsc_pkg::MD_LIT;
			end else if (b == "-") mode_d = jvsc_pkg::MD_NSIGN;
			else if (c.digit) mode_d = jvsc_pkg::MD_NINT;
			else begin
				fin = 1'b1; ver = 1'b1;
			end
		end
		if (pop) begin
			nest_d = nest_q - 1'b1;
			top_d  = below_q;
			if (nest_d == '0) fin = 1'b1;
			else mode_d = jvsc_pkg::MD_AFTER;
		end
		if (mode_q == jvsc_pkg::MD_DONE) begin
			fin = 1'b0;
		end else if (!fin && q_item.last) begin
			fin = 1'b1;
			ver = !(nest_d == '0 && (mode_d == jvsc_pkg::MD_NINT ||
				mode_d == jvsc_pkg::MD_NFRAC || mode_d == jvsc_pkg::MD_NEXP));
		end
		if (fin) mode_d = jvsc_pkg::MD_DONE;
	end

	assign rd_addr = (nest_d >= NW'(2)) ? SW'(nest_d - NW'(2)) : '0;

	always_ff @(posedge clk) begin
		if (q_pop && push) stk_q[SW'(nest_q)] <= top_d;
		if (q_pop) below_q <= push ? top_q : stk_q[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= jvsc_pkg::MD_VALUE;
			sub_q   <= jvsc_pkg::SB_CHAR;
			rule_q  <= jvsc_pkg::UR_ANY;
			key_q   <= 1'b0;
			nest_q  <= '0;
			lit_q   <= '0;
			hex_q   <= '0;
			hcnt_q  <= '0;
			pend_q  <= '0;
			top_q   <= 1'b0;
			out_v_q <= 1'b0;
			out_d_q <= 1'b0;
		end else begin
			if (q_pop && fin) begin
				out_v_q <= 1'b1;
				out_d_q <= ver;
			end else if (out_ready) begin
				out_v_q <= 1'b0;
			end
			if (q_pop) begin
				if (q_item.last) begin
					mode_q <= jvsc_pkg::MD_VALUE;
					sub_q  <= jvsc_pkg::SB_CHAR;
					rule_q <= jvsc_pkg::UR_ANY;
					key_q  <= 1'b0;
					nest_q <= '0;
					lit_q  <= '0;
					hex_q  <= '0;
					hcnt_q <= '0;
					pend_q <= '0;
					top_q  <= 1'b0;
				end else begin
					mode_q <= mode_d;
					sub_q  <= sub_d;
					rule_q <= rule_d;
					key_q  <= key_d;
					nest_q <= nest_d;
					lit_q  <= lit_d;
					hex_q  <= hex_d;
					hcnt_q <= hcnt_d;
					pend_q <= pend_d;
					top_q  <= top_d;
				end
			end
		end
	end

	a_nest_bound: assert property (@(posedge clk) disable iff (!arst_n)
		nest_q <= NW'(MAX_NEST + 1))
		else $error("nesting level beyond stack depth");

	a_open_needs_nest: assert property (@(posedge clk) disable iff (!arst_n)
		(mode_q == jvsc_pkg::MD_AFTER || mode_q == jvsc_pkg::MD_ARR1 ||
		 mode_q == jvsc_pkg::MD_OBJ1 || mode_q == jvsc_pkg::MD_KEY) |-> nest_q != '0)
		else $error("container mode with empty stack");

	a_utf8_in_string: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q != '0 |-> (mode_q == jvsc_pkg::MD_STR || mode_q == jvsc_pkg::MD_DONE))
		else $error("UTF-8 continuation pending outside string");

	a_verdict_from_pop: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_v_q) |-> $past(q_pop))
		else $error("verdict without consumed byte");

endmodule

### design/json_value_syntax_checker.sv
// Top level of the JSON value syntax checker: byte queue front and parser back.
// Path: an accepted byte is stored in the front-end queue; the parser consumes it
// from the queue head, and a verdict it completes is registered onto m_tvalid.
// Throughput: one byte per cycle, stalled while a verdict waits on m_tready.
// Reset: arst_n clears the queue, parser state and verdict register; state also
// returns to its start after every byte flagged by s_tlast.
`timescale 1ns / 1ps
module json_value_syntax_checker #(
	parameter int MAX_NEST = 64
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] text_byte
	input  logic       s_tlast,
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata    // [0] verdict, [7:1] zero
);

	logic            q_valid;
	logic            q_pop;
	jvsc_pkg::item_t q_item;
	logic            verdict;

	jvsc_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_text  (s_tdata),
		.in_last  (s_tlast),
		.q_valid  (q_valid),
		.q_pop    (q_pop),
		.q_item   (q_item)
	);

	jvsc_back #(
		.MAX_NEST (MAX_NEST)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_valid     (q_valid),
		.q_pop       (q_pop),
		.q_item      (q_item),
		.out_valid   (m_tvalid),
		.out_ready   (m_tready),
		.out_verdict (verdict)
	);

	assign m_tdata = {7'd0, verdict};

endmodule
